@@ hw/rtl/usan_pkg.sv @@
// ============================================================================
// usan_pkg
// Types and constants shared by the UTF-8 stream sanitiser modules.
// ============================================================================
package usan_pkg;

    // Command codes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Byte class limits
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD_LO   = 8'hC2;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD_HI   = 8'hF4;
    localparam logic [7:0] LEAD_ED   = 8'hED;
    localparam logic [7:0] SEC_A0    = 8'hA0;
    localparam logic [7:0] SEC_90    = 8'h90;

    // Replacement character U+FFFD
    localparam logic [7:0] REP_B0 = 8'hEF;
    localparam logic [7:0] REP_B1 = 8'hBF;
    localparam logic [7:0] REP_B2 = 8'hBD;

    // Most bytes one input can produce
    localparam int MAX_OUT = 6;

    // One queued job: the bytes one input produces, in order
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              cnt;
    } t_job;

endpackage

@@ hw/rtl/usan_if.sv @@
// ============================================================================
// usan_if
// Valid/ready channel interfaces for the sanitiser input and output streams.
// ============================================================================
interface usan_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface usan_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ hw/rtl/usan_front.sv @@
// ============================================================================
// usan_front
// Accepts bytes and flushes, tracks the pending sequence and builds the list
// of output bytes each transfer causes.
// ============================================================================
module usan_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    usan_in_if.sink       i_in,
    input  logic          i_full,
    output logic          o_push,
    output usan_pkg::t_job o_job
);

    logic [7:0] r_held [3];
    logic [1:0] r_hc;
    logic [2:0] r_el;
    logic [1:0] n_hc;
    logic [2:0] n_el;

    logic       acc;
    logic [7:0] b;
    logic       is_cont;
    logic       sec_ok;
    logic       cont;
    logic       release_seq;
    logic       fresh;
    logic       is_lead;

    // prefix list (replacement or released sequence) and fresh-byte list
    logic [3:0][7:0] p;
    logic [2:0]      pn;
    logic [2:0][7:0] f;
    logic [1:0]      fn;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;

    // Classification
    always_comb begin
        is_cont = (b >= usan_pkg::CONT_LO) && (b <= usan_pkg::CONT_HI);
        sec_ok  = 1'b1;
        if (r_held[0] == usan_pkg::LEAD3_LO && b < usan_pkg::SEC_A0) sec_ok = 1'b0;
        if (r_held[0] == usan_pkg::LEAD_ED  && b >= usan_pkg::SEC_A0) sec_ok = 1'b0;
        if (r_held[0] == usan_pkg::LEAD4_LO && b < usan_pkg::SEC_90) sec_ok = 1'b0;
        if (r_held[0] == usan_pkg::LEAD_HI  && b >= usan_pkg::SEC_90) sec_ok = 1'b0;
        cont        = is_cont && !(r_hc == 2'd1 && !sec_ok);
        release_seq = ({1'b0, r_hc} + 3'd1 >= r_el) || (r_hc == 2'd3);
        is_lead     = (b >= usan_pkg::LEAD_LO) && (b <= usan_pkg::LEAD_HI);
    end

    // Output list and next state
    always_comb begin
        p     = '0;
        pn    = 3'd0;
        f     = '0;
        fn    = 2'd0;
        fresh = 1'b0;
        n_hc  = r_hc;
        n_el  = r_el;
        if (i_in.command == usan_pkg::CMD_FLUSH) begin
            if (r_hc != 2'd0) begin
                p    = {8'h00, usan_pkg::REP_B2, usan_pkg::REP_B1, usan_pkg::REP_B0};
                pn   = 3'd3;
                n_hc = 2'd0;
            end
        end else begin
            if (r_hc == 2'd0) begin
                fresh = 1'b1;
            end else if (cont) begin
                if (release_seq) begin
                    case (r_hc)
                        2'd1: begin
                            p  = {8'h00, 8'h00, b, r_held[0]};
                            pn = 3'd2;
                        end
                        2'd2: begin
                            p  = {8'h00, b, r_held[1], r_held[0]};
                            pn = 3'd3;
                        end
                        default: begin
                            p  = {b, r_held[2], r_held[1], r_held[0]};
                            pn = 3'd4;
                        end
                    endcase
                    n_hc = 2'd0;
                end else begin
                    n_hc = r_hc + 2'd1;
                end
            end else begin
                p     = {8'h00, usan_pkg::REP_B2, usan_pkg::REP_B1, usan_pkg::REP_B0};
                pn    = 3'd3;
                n_hc  = 2'd0;
                fresh = 1'b1;
            end
            if (fresh) begin
                if (b < usan_pkg::CONT_LO) begin
                    f  = {8'h00, 8'h00, b};
                    fn = 2'd1;
                end else if (is_lead) begin
                    n_hc = 2'd1;
                    if (b < usan_pkg::LEAD3_LO)      n_el = 3'd2;
                    else if (b < usan_pkg::LEAD4_LO) n_el = 3'd3;
                    else                             n_el = 3'd4;
                end else begin
                    f  = {usan_pkg::REP_B2, usan_pkg::REP_B1, usan_pkg::REP_B0};
                    fn = 2'd3;
                end
            end
        end
    end

    // Concatenate the two lists into the job
    always_comb begin
        logic [2:0] j;
        o_job.cnt = pn + {1'b0, fn};
        for (int k = 0; k < usan_pkg::MAX_OUT; k++) begin
            j = 3'(k) - pn;
            if (3'(k) < pn) o_job.bytes[k] = p[k[1:0]];
            else            o_job.bytes[k] = f[j[1:0]];
        end
    end

    assign o_push = acc && (o_job.cnt != 3'd0);

    // Pending-sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= 2'd0;
            r_el <= 3'd0;
        end else if (acc) begin
            r_hc <= n_hc;
            r_el <= n_el;
        end
    end

    // Held bytes: lead on a fresh lead, continuation appended otherwise
    always_ff @(posedge i_clk) begin
        if (acc && i_in.command == usan_pkg::CMD_DATA) begin
            if (fresh && is_lead) begin
                r_held[0] <= b;
            end else if (r_hc != 2'd0 && cont && !release_seq) begin
                case (r_hc)
                    2'd1:    r_held[1] <= b;
                    default: r_held[2] <= b;
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/usan_queue.sv @@
// ============================================================================
// usan_queue
// Two-entry job queue between the front and back ends.
// ============================================================================
module usan_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  usan_pkg::t_job i_job,
    input  logic           i_pop,
    output usan_pkg::t_job o_head,
    output logic           o_empty,
    output logic           o_full
);

    usan_pkg::t_job r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_mem[r_rptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

endmodule

@@ hw/rtl/usan_back.sv @@
// ============================================================================
// usan_back
// Serialises queued jobs into single output bytes through an output register.
// ============================================================================
module usan_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  usan_pkg::t_job i_head,
    input  logic           i_empty,
    output logic           o_pop,
    usan_out_if.source     o_out
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       is_last;

    assign load    = !i_empty && (!r_valid || o_out.ready);
    assign is_last = (r_idx + 3'd1 == i_head.cnt);
    assign o_pop   = load && is_last;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

    // Byte index within the head job and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= is_last ? 3'd0 : r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= is_last;
        end
    end

endmodule

@@ hw/rtl/utf8_stream_sanitizer.sv @@
// ============================================================================
// utf8_stream_sanitizer
// Byte-stream UTF-8 validator that replaces broken input with U+FFFD.
// ============================================================================
//  channel | dir | fields            | notes
//  i_in    | in  | command, in_byte  | flush when command is 1
//  o_out   | out | out_byte, last    | last marks the final byte of a transfer
//
//  One input transfer per cycle while the job queue has room; the front end
//  decides the whole output of a transfer in the cycle it is accepted.
//  The back end sends one output byte per cycle while the output is ready;
//  a transfer produces 1 to 6 bytes, and zero-byte transfers are not queued
//  and produce no output. Output stalls back up through the two-entry queue.
//  Reset is synchronous, active low, and clears the pending sequence.
// ============================================================================
module utf8_stream_sanitizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    usan_in_if.sink    i_in,
    usan_out_if.source o_out
);

    usan_pkg::t_job job;
    usan_pkg::t_job head;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;

    usan_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    usan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    usan_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for utf8_stream_sanitizer. A tracker class models the
// sanitiser byte by byte and queues the output bytes each input transfer
// should cause; every output transfer is compared with the oldest of them.
// Directed bytes cover the range limits, the second-byte bounds after E0, ED
// and F4, stray and broken sequences and flushes. Random traffic is mostly
// well-formed UTF-8 with truncated sequences, noise and flushes mixed in,
// under three idle profiles and one long output hold-off.
// ============================================================================

typedef struct {
    logic [7:0] data;
    logic       last;
} t_out_byte;

// Tracks the sanitiser state and the output bytes still owed by the block
class utf8_out_tracker;
    t_out_byte  pending_out[$];
    logic [7:0] step_bytes[$];
    logic [7:0] held [3];
    logic [1:0] held_cnt;
    logic [2:0] seq_len;
    int         errors;
    int         n_in;
    int         n_out;
    int         n_rep;

    function new();
        held_cnt = '0;
        seq_len  = '0;
        errors   = 0;
        n_in     = 0;
        n_out    = 0;
        n_rep    = 0;
    endfunction

    function bit second_in_range(logic [7:0] lead, logic [7:0] b);
        if (lead == usan_pkg::LEAD3_LO && b < usan_pkg::SEC_A0) return 1'b0;
        if (lead == usan_pkg::LEAD_ED && b >= usan_pkg::SEC_A0) return 1'b0;
        if (lead == usan_pkg::LEAD4_LO && b < usan_pkg::SEC_90) return 1'b0;
        if (lead == usan_pkg::LEAD_HI && b >= usan_pkg::SEC_90) return 1'b0;
        return 1'b1;
    endfunction

    // Append one byte to the output of the current input transfer
    function void owe_byte(logic [7:0] b);
        step_bytes.insert(step_bytes.size(), b);
    endfunction

    // Append the replacement character EF BF BD
    function void owe_replacement();
        owe_byte(usan_pkg::REP_B0);
        owe_byte(usan_pkg::REP_B1);
        owe_byte(usan_pkg::REP_B2);
        n_rep++;
    endfunction

    // Work out the bytes one accepted input transfer produces
    function void sanitise_input(logic cmd, logic [7:0] b);
        bit         is_cont;
        bit         taken;
        t_out_byte  item;
        taken = 1'b0;
        n_in++;
        step_bytes.delete();
        if (cmd == usan_pkg::CMD_FLUSH) begin
            if (held_cnt != 0) begin
                owe_replacement();
                held_cnt = '0;
            end
        end else begin
            if (held_cnt != 0) begin
                is_cont = (b >= usan_pkg::CONT_LO && b <= usan_pkg::CONT_HI) &&
                          !(held_cnt == 1 && !second_in_range(held[0], b));
                if (is_cont) begin
                    if (held_cnt + 1 >= seq_len || held_cnt >= 3) begin
                        for (int i = 0; i < held_cnt && i < 3; i++)
                            owe_byte(held[i]);
                        owe_byte(b);
                        held_cnt = '0;
                    end else begin
                        held[held_cnt] = b;
                        held_cnt = held_cnt + 1'b1;
                    end
                    taken = 1'b1;
                end else begin
                    // broken sequence: replacement, then the byte afresh
                    owe_replacement();
                    held_cnt = '0;
                end
            end
            if (!taken) begin
                if (b < usan_pkg::CONT_LO) begin
                    owe_byte(b);
                end else if (b >= usan_pkg::LEAD_LO && b <= usan_pkg::LEAD_HI) begin
                    held[0]  = b;
                    held_cnt = 2'd1;
                    seq_len  = (b < usan_pkg::LEAD3_LO) ? 3'd2 :
                               ((b < usan_pkg::LEAD4_LO) ? 3'd3 : 3'd4);
                end else begin
                    // stray byte
                    owe_replacement();
                end
            end
        end
        foreach (step_bytes[i]) begin
            item.data = step_bytes[i];
            item.last = (i == step_bytes.size() - 1);
            pending_out.insert(pending_out.size(), item);
        end
    endfunction

    // Compare one output transfer with the oldest owed byte
    function void check_output_byte(logic [7:0] data, logic last, time t);
        t_out_byte want;
        n_out++;
        if (pending_out.size() == 0) begin
            $display("%0t: unexpected output transfer, expected none, actual %02h last %0b",
                     t, data, last);
            errors++;
            return;
        end
        want = pending_out.pop_front();
        if (data !== want.data) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     t, want.data, data);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     t, want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return pending_out.size();
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PER_PHASE = 24;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    usan_in_if  in_ch ();
    usan_out_if out_ch ();

    utf8_out_tracker tracker;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_req     = 0;
    int hold_ack     = 0;
    int hold_left    = 0;
    int cycle_cnt    = 0;
    int n_sent       = 0;

    utf8_stream_sanitizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.command  = usan_pkg::CMD_DATA;
        in_ch.in_byte  = 8'h00;
        out_ch.ready   = 1'b0;
        tracker = new();
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still owed",
                     cycle_cnt, tracker.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output ready: random idling, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Monitor: note inputs before checking outputs of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                tracker.sanitise_input(in_ch.command, in_ch.in_byte);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                tracker.check_output_byte(out_ch.out_byte, out_ch.last, $time);
        end
    end

    // Offer one input transfer, with random idle cycles in front
    task automatic send_byte(input logic cmd, input logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.in_byte <= data;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        n_sent++;
    endtask

    // Lead byte of the given length, then continuations up to cut bytes
    task automatic send_sequence(input int len, input int cut);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        case (len)
            2:       lead = 8'($urandom_range(usan_pkg::LEAD_LO, usan_pkg::LEAD3_LO - 1));
            3:       lead = 8'($urandom_range(usan_pkg::LEAD3_LO, usan_pkg::LEAD4_LO - 1));
            default: lead = 8'($urandom_range(usan_pkg::LEAD4_LO, usan_pkg::LEAD_HI));
        endcase
        lo = usan_pkg::CONT_LO;
        hi = usan_pkg::CONT_HI;
        if (lead == usan_pkg::LEAD3_LO) lo = usan_pkg::SEC_A0;
        if (lead == usan_pkg::LEAD_ED)  hi = usan_pkg::SEC_A0 - 8'd1;
        if (lead == usan_pkg::LEAD4_LO) lo = usan_pkg::SEC_90;
        if (lead == usan_pkg::LEAD_HI)  hi = usan_pkg::SEC_90 - 8'd1;
        send_byte(usan_pkg::CMD_DATA, lead);
        for (int i = 1; i < cut; i++) begin
            if (i == 1)
                send_byte(usan_pkg::CMD_DATA, 8'($urandom_range(lo, hi)));
            else
                send_byte(usan_pkg::CMD_DATA,
                          8'($urandom_range(usan_pkg::CONT_LO, usan_pkg::CONT_HI)));
        end
    endtask

    // One random unit: mostly well-formed text, some truncation, noise and flushes
    task automatic send_random_unit();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(2, 4);
        if (kind < 35)
            send_byte(usan_pkg::CMD_DATA, 8'($urandom_range(0, usan_pkg::CONT_LO - 1)));
        else if (kind < 75)
            send_sequence(len, len);
        else if (kind < 87)
            send_sequence(len, $urandom_range(1, len - 1));
        else if (kind < 95)
            send_byte(usan_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
        else
            send_byte(usan_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    // Main sequence
    initial begin
        logic [7:0] directed [$];
        int start;
        directed = {8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF,
                    8'hC2, 8'h80, 8'hDF, 8'hBF,
                    8'hE0, 8'hA0, 8'h80,
                    8'hED, 8'h9F, 8'hBF,
                    8'hF4, 8'h8F, 8'hBF, 8'hBF,
                    8'hE0, 8'h9F,
                    8'hED, 8'hA0};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: limits, second-byte bounds after E0, ED and F4, stray and broken bytes
        foreach (directed[i])
            send_byte(usan_pkg::CMD_DATA, directed[i]);
        // flush with nothing pending, then with a sequence pending
        send_byte(usan_pkg::CMD_FLUSH, 8'hFF);
        send_byte(usan_pkg::CMD_DATA, 8'hC2);
        send_byte(usan_pkg::CMD_FLUSH, 8'h00);
        send_byte(usan_pkg::CMD_DATA, 8'hF4);
        send_byte(usan_pkg::CMD_DATA, 8'h90);

        // Random phases: receiver idles, then sender idles, then neither
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 10; snk_idle_pct = 64; end
                1:       begin src_idle_pct = 64; snk_idle_pct = 10; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            // long output stall while the input keeps offering
            if (phase == 2)
                hold_req++;
            start = n_sent;
            while (n_sent - start < RAND_PER_PHASE)
                send_random_unit();
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d input transfers and %0d output transfers, %0d replacements,",
                 tracker.n_in, tracker.n_out, tracker.n_rep);
        $display("three idle profiles and a %0d-cycle output hold-off.", HOLD_CYCLES);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/usan_pkg.sv
hw/rtl/usan_if.sv
hw/rtl/usan_front.sv
hw/rtl/usan_queue.sv
hw/rtl/usan_back.sv
hw/rtl/utf8_stream_sanitizer.sv
verif/testbench.sv
